FILE: rtl/tsa_pkg.sv
`default_nettype none
package tsa_pkg;

  localparam int MAX_SLOTS  = 64;
  localparam int WAYS       = 2;
  localparam int AGE_W      = 16;
  localparam int TAG_W      = 32;
  localparam int FRAME_W    = 32;
  localparam int LIMIT_W    = 32;
  localparam int CNT_W      = 7;
  localparam int SLOT_IDX_W = 6;
  localparam int CFG_DATA_W = 32;

  localparam int SET_CNT    = MAX_SLOTS / WAYS;
  localparam int SET_W      = $clog2(SET_CNT);
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int N_W        = SLOT_W + 1;
  localparam int MOD_W      = SET_W + 1;
  localparam int ENTRY_W    = TAG_W + AGE_W;
  localparam int ROW_W      = WAYS * ENTRY_W;

  localparam int DIV_STEP   = 4;
  localparam int DIV_CYC    = FRAME_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYC);

  localparam logic [TAG_W-1:0] TAG_INVALID = '1;
  localparam logic [AGE_W-1:0] AGE_TOP     = '1;

  localparam logic CFG_SLOT_COUNT  = 1'b0;
  localparam logic CFG_FRAME_LIMIT = 1'b1;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rd_en;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/tsa_ctrl.sv
`default_nettype none
module tsa_ctrl
  import tsa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire dp_sts_t   sts,
  output ctrl_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = sts.skip ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      ST_DONE: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/tsa_dp.sv
`default_nettype none
module tsa_dp
  import tsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctrl_cmd_t             cmd,
  output dp_sts_t                    sts,
  input  wire logic [FRAME_W-1:0]    s_tdata,
  input  wire logic                  s_tuser,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [7:0]                 m_tdata
);

  logic [CNT_W-1:0]     slot_count;
  logic [LIMIT_W-1:0]   frame_limit;

  logic [FRAME_W-1:0]   frame;
  logic                 skip;
  logic                 clear;
  logic                 reject;

  logic [FRAME_W-1:0]   dividend;
  logic [SET_W-1:0]     rem;
  logic [SET_W-1:0]     rem_next;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [N_W-1:0]       n_use;
  logic [MOD_W-1:0]     modulus;
  logic [MOD_W-1:0]     trial;

  logic [ROW_W-1:0]     mem [SET_CNT];
  logic [SET_CNT-1:0]   row_valid;
  logic [ROW_W-1:0]     rd_row;
  logic                 rd_valid;

  logic [TAG_W-1:0]     tag0;
  logic [TAG_W-1:0]     tag1;
  logic [AGE_W-1:0]     age0;
  logic [AGE_W-1:0]     age1;
  logic [AGE_W-1:0]     inc0;
  logic [AGE_W-1:0]     inc1;
  logic [TAG_W-1:0]     new_tag0;
  logic [TAG_W-1:0]     new_tag1;
  logic [AGE_W-1:0]     new_age0;
  logic [AGE_W-1:0]     new_age1;
  logic                 hit;
  logic                 way;
  logic [SLOT_W-1:0]    slot;

  logic                 in_skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count  <= CNT_W'(MAX_SLOTS);
      frame_limit <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLOT_COUNT:  slot_count  <= cfg_data[CNT_W-1:0];
        CFG_FRAME_LIMIT: frame_limit <= cfg_data[LIMIT_W-1:0];
        default:         slot_count  <= slot_count;
      endcase
    end
  end

  always_comb begin
    if (int'(slot_count) > MAX_SLOTS) begin
      n_use = N_W'(MAX_SLOTS);
    end else begin
      n_use = N_W'(slot_count);
    end
    modulus = n_use[N_W-1:1];
    if (modulus == '0) begin
      modulus = MOD_W'(1);
    end
  end

  assign in_skip = (s_tuser == KIND_CLEAR) || (s_tdata >= frame_limit);

  // for even n, (frame mod n) rounded down to even is twice the set index (frame >> 1) mod (n / 2)
  always_comb begin
    rem_next = rem;
    trial    = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial = {rem_next, dividend[FRAME_W-1-k]};
      if (trial >= modulus) begin
        trial = trial - modulus;
      end
      rem_next = trial[SET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame    <= s_tdata;
      skip     <= in_skip;
      clear    <= (s_tuser == KIND_CLEAR);
      reject   <= (s_tuser == KIND_LOOKUP) && (s_tdata >= frame_limit);
      dividend <= {1'b0, s_tdata[FRAME_W-1:1]};
      rem      <= '0;
      div_cnt  <= '0;
    end else if (cmd.div_step) begin
      dividend <= dividend << DIV_STEP;
      rem      <= rem_next;
      div_cnt  <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_row   <= mem[rem];
      rd_valid <= row_valid[rem];
    end
  end

  always_comb begin
    tag0 = rd_valid ? rd_row[TAG_W-1:0] : TAG_INVALID;
    age0 = rd_valid ? rd_row[ENTRY_W-1:TAG_W] : '0;
    tag1 = rd_valid ? rd_row[ENTRY_W+TAG_W-1:ENTRY_W] : TAG_INVALID;
    age1 = rd_valid ? rd_row[ROW_W-1:ENTRY_W+TAG_W] : '0;
    inc0 = (age0 == AGE_TOP) ? age0 : age0 + 1'b1;
    inc1 = (age1 == AGE_TOP) ? age1 : age1 + 1'b1;

    new_tag0 = tag0;
    new_tag1 = tag1;
    new_age0 = inc0;
    new_age1 = inc1;
    hit      = 1'b1;
    way      = 1'b0;
    if (tag0 == frame) begin
      new_age0 = '0;
      new_age1 = age1;
    end else if (tag1 == frame) begin
      new_age1 = '0;
      way      = 1'b1;
    end else begin
      hit = 1'b0;
      if (inc1 > inc0) begin
        way      = 1'b1;
        new_tag1 = frame;
        new_age1 = '0;
      end else begin
        new_tag0 = frame;
        new_age0 = '0;
      end
    end
    slot = {rem, way};
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && !skip) begin
      mem[rem] <= {new_age1, new_tag1, new_age0, new_tag0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.finish) begin
      if (clear) begin
        row_valid <= '0;
      end else if (!skip) begin
        row_valid[rem] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (skip) begin
        m_tdata <= {reject, SLOT_IDX_W'(0), 1'b0};
      end else begin
        m_tdata <= {1'b0, SLOT_IDX_W'(slot), hit};
      end
    end
  end

  always_comb begin
    sts.skip     = in_skip;
    sts.div_last = (div_cnt == DIV_CNT_W'(DIV_CYC - 1));
    sts.out_free = !m_tvalid || m_tready;
  end

endmodule
`default_nettype wire

FILE: rtl/two_way_set_assoc_tag_aging_core.sv
`default_nettype none
// Two-way set-associative tag store with saturating age counters. A lookup request
// carries a frame number in s_tdata (s_tuser low); the frame maps to the set
// (frame >> 1) mod (slot_count / 2), with slot_count capped at 64; the reply gives
// hit, the slot found or reserved, and rejected when the frame is not below
// frame_limit. A lookup computes the set-index remainder (4 dividend bits per
// cycle), reads the set row from the tag memory and then updates the row and loads
// the result register, waiting while the previous result is untaken. A clear
// request (s_tuser high) or a rejected lookup skips the division and the read and
// puts its result in the result register, with the same wait; a clear resets all
// per-set valid bits at once, so there is no sweep after reset or clear. One
// request is in flight at a time; a new request is taken while the previous
// result waits in the output register.
module two_way_set_assoc_tag_aging_core
  import tsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [FRAME_W-1:0]    s_tdata,   // frame_number
  input  wire logic                  s_tuser,   // kind
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [7:0]                 m_tdata,   // rejected, slot_index[5:0], hit
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  tsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tsa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in flight");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_busy_steps: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step || cmd.rd_en |-> !s_tready)
    else $error("datapath working while idle");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_tvalid)
    else $error("finished request produced no result");

  a_reject_no_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[7] && m_tdata[0]))
    else $error("rejected result marked as hit");

endmodule
`default_nettype wire
